FILE: hdl/bstep_pkg.sv
// ----------------------------------------------------------------------------
// bstep_pkg
// Shared command codes and field types of the two-axis Bresenham stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package bstep_pkg;

  // Command field of an input beat.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Direction bit values as seen on dir_x and dir_y.
  localparam logic DIR_NEG = 1'b0;
  localparam logic DIR_POS = 1'b1;

  // Flags carried with every result beat.
  typedef struct packed {
    logic step_x;
    logic dir_x;
    logic step_y;
    logic dir_y;
    logic busy_res;
    logic move_done;
    logic rejected;
  } flags_t;

endpackage

`default_nettype wire

FILE: hdl/bresenham_two_axis_step_generator_unit.sv
// ----------------------------------------------------------------------------
// bresenham_two_axis_step_generator_unit
// Two-axis linear interpolator: load a target, then each tick beat during a move
// steps the major axis and, by Bresenham error, the minor axis.
// ----------------------------------------------------------------------------
// The unit takes one input beat in every clock cycle and returns exactly one
// result beat for it, in the next cycle, from a single output register. A load
// or a tick is worked out in the cycle it is accepted, directly from the
// input ports and the held move state; the longest path is one
// POS_BITS+1 bit subtract, absolute value and magnitude compare on a load,
// or the error add, compare and subtract on a tick. The input side is only
// stalled while a finished result waits and the output side is stalled too.
`default_nettype none

module bresenham_two_axis_step_generator_unit #(
  parameter int POS_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Input channel.
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic                       command,
  input  wire logic signed [POS_BITS-1:0] target_x,
  input  wire logic signed [POS_BITS-1:0] target_y,
  // Result channel.
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic                       step_x,
  output      logic                       dir_x,
  output      logic                       step_y,
  output      logic                       dir_y,
  output      logic                       busy_res,
  output      logic                       move_done,
  output      logic                       rejected,
  output      logic signed [POS_BITS-1:0] pos_x,
  output      logic signed [POS_BITS-1:0] pos_y
);

  localparam int W = POS_BITS;

  // Move state.
  logic [W-1:0] position_x, position_x_next;
  logic [W-1:0] position_y, position_y_next;
  logic [W-1:0] major_delta, major_delta_next;
  logic [W-1:0] minor_delta, minor_delta_next;
  logic [W:0]   error_acc, error_acc_next;
  logic [W-1:0] steps_left, steps_left_next;
  logic         x_is_major, x_is_major_next;
  logic [1:0]   direction_bits, direction_bits_next;
  logic         active, active_next;

  // Output register.
  bstep_pkg::flags_t flags, flags_next;
  logic [W-1:0]      pos_x_reg;
  logic [W-1:0]      pos_y_reg;

  logic accept;

  // Load datapath.
  logic [W:0]   dx_full, dy_full;
  logic [W:0]   dx_abs, dy_abs;
  logic [W-1:0] ax, ay;
  logic         dx_pos, dy_pos;
  logic         ax_major;

  // Tick datapath.
  logic [W:0]   err_sum;
  logic         minor_step;
  logic         sx, sy;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Deltas need one extra bit: target and position span the full range.
  assign dx_full  = {target_x[W-1], target_x} - {position_x[W-1], position_x};
  assign dy_full  = {target_y[W-1], target_y} - {position_y[W-1], position_y};
  assign dx_abs   = dx_full[W] ? (~dx_full + 1'b1) : dx_full;
  assign dy_abs   = dy_full[W] ? (~dy_full + 1'b1) : dy_full;
  assign ax       = dx_abs[W-1:0];
  assign ay       = dy_abs[W-1:0];
  assign dx_pos   = !dx_full[W] && (dx_full != '0);
  assign dy_pos   = !dy_full[W] && (dy_full != '0);
  assign ax_major = ax > ay;

  // The error stays below the major delta, so the sum fits in W+1 bits.
  assign err_sum    = error_acc + {1'b0, minor_delta};
  assign minor_step = err_sum >= {1'b0, major_delta};
  assign sx         = x_is_major ? 1'b1 : minor_step;
  assign sy         = x_is_major ? minor_step : 1'b1;

  always_comb begin
    position_x_next     = position_x;
    position_y_next     = position_y;
    major_delta_next    = major_delta;
    minor_delta_next    = minor_delta;
    error_acc_next      = error_acc;
    steps_left_next     = steps_left;
    x_is_major_next     = x_is_major;
    direction_bits_next = direction_bits;
    active_next         = active;
    flags_next          = '0;

    unique case (command)
      bstep_pkg::CMD_LOAD: begin
        if (active) begin
          flags_next.rejected = 1'b1;
        end else begin
          direction_bits_next = {dy_pos, dx_pos};
          x_is_major_next     = ax_major;
          major_delta_next    = ax_major ? ax : ay;
          minor_delta_next    = ax_major ? ay : ax;
          error_acc_next      = {2'b00, major_delta_next[W-1:1]};
          steps_left_next     = major_delta_next;
          active_next         = (major_delta_next != '0);
          flags_next.move_done = (major_delta_next == '0);
        end
      end
      bstep_pkg::CMD_TICK: begin
        if (active) begin
          error_acc_next = minor_step ? (err_sum - {1'b0, major_delta}) : err_sum;
          flags_next.step_x = sx;
          flags_next.step_y = sy;
          if (sx) begin
            position_x_next = (direction_bits[0] == bstep_pkg::DIR_POS) ?
                              position_x + 1'b1 : position_x - 1'b1;
          end
          if (sy) begin
            position_y_next = (direction_bits[1] == bstep_pkg::DIR_POS) ?
                              position_y + 1'b1 : position_y - 1'b1;
          end
          steps_left_next = steps_left - 1'b1;
          if (steps_left_next == '0) begin
            active_next          = 1'b0;
            flags_next.move_done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    flags_next.dir_x    = direction_bits_next[0];
    flags_next.dir_y    = direction_bits_next[1];
    flags_next.busy_res = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_x     <= '0;
      position_y     <= '0;
      major_delta    <= '0;
      minor_delta    <= '0;
      error_acc      <= '0;
      steps_left     <= '0;
      x_is_major     <= 1'b0;
      direction_bits <= '0;
      active         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        position_x     <= position_x_next;
        position_y     <= position_y_next;
        major_delta    <= major_delta_next;
        minor_delta    <= minor_delta_next;
        error_acc      <= error_acc_next;
        steps_left     <= steps_left_next;
        x_is_major     <= x_is_major_next;
        direction_bits <= direction_bits_next;
        active         <= active_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload holds while stalled because accept is low then.
  always_ff @(posedge clk) begin
    if (accept) begin
      flags     <= flags_next;
      pos_x_reg <= position_x_next;
      pos_y_reg <= position_y_next;
    end
  end

  assign step_x    = flags.step_x;
  assign dir_x     = flags.dir_x;
  assign step_y    = flags.step_y;
  assign dir_y     = flags.dir_y;
  assign busy_res  = flags.busy_res;
  assign move_done = flags.move_done;
  assign rejected  = flags.rejected;
  assign pos_x     = pos_x_reg;
  assign pos_y     = pos_y_reg;

  // The error term never reaches the major delta during a move.
  a_error_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> (error_acc < {1'b0, major_delta}))
    else $error("error accumulator reached the major delta");

  // A tick during a move always steps the major axis.
  a_tick_steps: assert property (@(posedge clk) disable iff (rst)
    (accept && active && command == bstep_pkg::CMD_TICK) |=>
      (out_valid && (flags.step_x || flags.step_y)))
    else $error("tick during a move gave no step");

  // A rejected load leaves the move running; a finished move is idle.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && flags.rejected) |-> flags.busy_res)
    else $error("rejected load without a running move");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && flags.move_done) |-> (!flags.busy_res && !active))
    else $error("move done while still busy");

endmodule

`default_nettype wire
